// ----- rtl/cms_pkg.sv -----
// Package for the per-switch count-min sketch: types, constants, MD5 tables.
// No dependencies.
`default_nettype none
package cms_pkg;

   localparam int NUM_SWITCHES_DEF = 4;
   localparam int ROWS_DEF         = 4;
   localparam int MAX_WIDTH_DEF    = 1024;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WIDTH_W    = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_3 = 3'd4;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [62:0] SENTINEL = 63'd999999999999;
   localparam logic [62:0] CNT_MAX  = {63{1'b1}};

   typedef struct packed {
      logic        kind;
      logic [1:0]  switch_id;
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [4:0]  key_bytes;
      logic [15:0] packet_size;
   } req_type;

   typedef struct packed {
      logic [62:0] estimate;
      logic        any_switch;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_HASH, ST_MOD, ST_ACCESS, ST_DONE
   } state_type;

   function automatic logic [31:0] md5_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
         32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
         32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
         32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
         32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
         32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
         32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
         32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
         32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
         32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
         32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
         32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
         32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
         32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
         32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
         32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
      return k[i];
   endfunction

   function automatic logic [4:0] md5_s(input logic [5:0] i);
      logic [4:0] s [16];
      s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return s[{i[5:4], i[1:0]}];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/cms_md5.sv -----
// Iterative single-block MD5, one round per cycle; outputs the sum of digest words.
// Depends on cms_pkg.
`default_nettype none
module cms_md5 (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  key_low,
   input  wire logic [63:0]  key_high,
   input  wire logic [4:0]   key_bytes,
   output logic              done,
   output logic [31:0]       folded
);
   logic [511:0] blk_ff, blk_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         run_ff, run_in, done_ff, done_in;
   logic [31:0]  f, g_word, sum, rot;
   logic [3:0]   g;
   logic [4:0]   n;
   logic [4:0]   sh;
   logic [127:0] key;

   always_comb begin
      n = (key_bytes > 5'd16) ? 5'd16 : key_bytes;
      key = {key_high, key_low};
      blk_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < n) blk_in[8*i +: 8] = key[8*i +: 8];
         else if (5'(i) == n) blk_in[8*i +: 8] = 8'h80;
      end
      if (n == 5'd16) blk_in[135:128] = 8'h80;
      blk_in[455:448] = {n, 3'b000};
   end

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: begin f = (b_ff & c_ff) | (~b_ff & d_ff); g = rnd_ff[3:0]; end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'(5 * rnd_ff + 1);
         end
         2'd2: begin f = b_ff ^ c_ff ^ d_ff; g = 4'(3 * rnd_ff + 5); end
         default: begin f = c_ff ^ (b_ff | ~d_ff); g = 4'(7 * rnd_ff); end
      endcase
      g_word = blk_ff[32*g +: 32];
      sum = f + a_ff + cms_pkg::md5_k(rnd_ff) + g_word;
      sh = cms_pkg::md5_s(rnd_ff);
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   always_comb begin
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      rnd_in = rnd_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         a_in = 32'h67452301; b_in = 32'hefcdab89;
         c_in = 32'h98badcfe; d_in = 32'h10325476;
         rnd_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         a_in = d_ff; d_in = c_ff; c_in = b_ff; b_in = b_ff + rot;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      if (start) blk_ff <= blk_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      rnd_ff <= rnd_in;
   end

   assign done   = done_ff;
   assign folded = (a_ff + 32'h67452301) + (b_ff + 32'hefcdab89)
                 + (c_ff + 32'h98badcfe) + (d_ff + 32'h10325476);
endmodule
`default_nettype wire

// ----- rtl/cms_mod.sv -----
// Restoring divider remainder unit: value mod divisor, one bit per cycle.
// Depends on cms_pkg.
`default_nettype none
module cms_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [31:0]                 value,
   input  wire logic [cms_pkg::WIDTH_W-1:0] divisor,
   output logic                             done,
   output logic [cms_pkg::WIDTH_W-1:0]      remainder
);
   localparam int W = cms_pkg::WIDTH_W;
   logic [31:0] val_ff, val_in;
   logic [W:0]  rem_ff, rem_in, trial;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   always_comb begin
      val_in = val_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff[W-1:0], val_ff[31]};
      if (start) begin
         val_in = value; rem_in = '0; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         // shift in next dividend bit, subtract when it fits
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         val_in = {val_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      val_ff <= val_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[W-1:0];
endmodule
`default_nettype wire

// ----- rtl/count_min_sketch_per_switch.sv -----
// Top level of the per-switch count-min sketch: control, counter memory, CSRs.
// Depends on cms_pkg, cms_md5, cms_mod.
`default_nettype none
// Per-switch count-min sketch. Assert start with a request while busy is low;
// the request is taken on that edge. The key is hashed by an MD5 core at one
// round per cycle (64 rounds, then the digest capture), then each row's index
// is reduced modulo the width in use by a bit-serial remainder unit. The
// counters sit in one single-port synchronous memory; an add does a
// read-modify-write per row (a read, then a write back), a query steps through
// every row of every switch, then drains the last read, and folds in the rows
// of present switches. A query answers with a one-cycle rsp_valid strobe in
// the first cycle with busy low; the receiver cannot stall it, so capture the
// response on that cycle. After reset the block clears the memory one entry
// per cycle and holds busy high meanwhile; CSR writes are taken at any time
// but belong only to idle periods.
module count_min_sketch_per_switch #(
   parameter int NUM_SWITCHES = cms_pkg::NUM_SWITCHES_DEF,
   parameter int ROWS         = cms_pkg::ROWS_DEF,
   parameter int MAX_WIDTH    = cms_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire cms_pkg::req_type               req_data,
   output logic                                rsp_valid,
   output cms_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_write,
   input  wire logic [cms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cms_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int SW_W    = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ADDR_W  = SW_W + ROW_W + COL_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int WW      = cms_pkg::WIDTH_W;
   localparam int CNTW    = (WW > COL_W + 1) ? WW : COL_W + 1;

   // ---- configuration registers
   logic [WW-1:0] width_ff;
   logic [31:0]   seed_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WW'(1024);
         seed_ff[0] <= 32'd0;
         seed_ff[1] <= 32'd1;
         seed_ff[2] <= 32'd2;
         seed_ff[3] <= 32'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            cms_pkg::CSR_WIDTH:  width_ff   <= csr_data[WW-1:0];
            cms_pkg::CSR_SEED_0: seed_ff[0] <= csr_data;
            cms_pkg::CSR_SEED_1: seed_ff[1] <= csr_data;
            cms_pkg::CSR_SEED_2: seed_ff[2] <= csr_data;
            cms_pkg::CSR_SEED_3: seed_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp width to [1, MAX_WIDTH]
   logic [WW-1:0] act_width;
   always_comb begin
      if (width_ff == '0) act_width = WW'(1);
      else if (CNTW'(width_ff) > CNTW'(MAX_WIDTH)) act_width = WW'(MAX_WIDTH);
      else act_width = width_ff;
   end

   // ---- request capture
   cms_pkg::req_type req_ff;
   logic             accept;
   cms_pkg::state_type state_ff, state_in;

   assign accept = start && !busy;
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
   end

   // ---- hash and modulo units
   logic        md5_done;
   logic [31:0] folded;
   logic [31:0] fold_ff;
   logic        mod_start, mod_done;
   logic [WW-1:0] mod_rem;

   cms_md5 u_md5 (
      .clock, .reset, .start(accept),
      .key_low(req_data.key_low), .key_high(req_data.key_high),
      .key_bytes(req_data.key_bytes), .done(md5_done), .folded
   );

   always_ff @(posedge clock) begin
      if (md5_done) fold_ff <= folded;
   end

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] idx_ff [ROWS];

   cms_mod u_mod (
      .clock, .reset, .start(mod_start),
      .value(fold_ff ^ seed_ff[2'(row_ff)]), .divisor(act_width),
      .done(mod_done), .remainder(mod_rem)
   );

   always_ff @(posedge clock) begin
      if (mod_done) idx_ff[row_ff] <= mod_rem[COL_W-1:0];
   end

   // ---- counter memory
   logic [62:0]       mem [DEPTH];
   logic [62:0]       rdata_ff;
   logic              we;
   logic [ADDR_W-1:0] addr;
   logic [62:0]       wdata;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   // ---- control
   logic [ADDR_W:0]   clr_ff, clr_in;
   logic [SW_W-1:0]   sw_ff, sw_in;
   logic              phase_ff, phase_in;    // add: 0 read, 1 write
   logic              rvld_ff, rvld_in;      // query read data due
   logic              mod_busy_ff, mod_busy_in;
   logic [NUM_SWITCHES-1:0] present_ff, present_in;
   logic [62:0]       best_ff, best_in;
   logic              rsp_ff, rsp_in;
   logic              last_rd_ff, last_rd_in;
   logic [62:0]       sat_sum;
   logic [63:0]       raw_sum;
   logic              sw_ok;

   assign sw_ok   = {{(8-2){1'b0}}, req_ff.switch_id} < 8'(NUM_SWITCHES);
   assign raw_sum = {1'b0, rdata_ff} + {48'd0, req_ff.packet_size};
   assign sat_sum = raw_sum[63] ? cms_pkg::CNT_MAX : raw_sum[62:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cms_pkg::ST_CLEAR:
            if (clr_ff == (ADDR_W+1)'(DEPTH - 1)) state_in = cms_pkg::ST_IDLE;
         cms_pkg::ST_IDLE:
            if (accept) state_in = cms_pkg::ST_HASH;
         cms_pkg::ST_HASH:
            if (md5_done) state_in = cms_pkg::ST_MOD;
         cms_pkg::ST_MOD:
            if (mod_done && row_ff == ROW_W'(ROWS - 1)) begin
               if (req_ff.kind == cms_pkg::KIND_ADD && !sw_ok) state_in = cms_pkg::ST_IDLE;
               else state_in = cms_pkg::ST_ACCESS;
            end
         cms_pkg::ST_ACCESS:
            if (req_ff.kind == cms_pkg::KIND_ADD) begin
               if (phase_ff && row_ff == ROW_W'(ROWS - 1)) state_in = cms_pkg::ST_IDLE;
            end else if (last_rd_ff && rvld_ff) begin
               state_in = cms_pkg::ST_DONE;
            end
         cms_pkg::ST_DONE:
            state_in = cms_pkg::ST_IDLE;
         default: state_in = cms_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      clr_in = clr_ff; sw_in = sw_ff; row_in = row_ff; phase_in = phase_ff;
      rvld_in = 1'b0; mod_busy_in = mod_busy_ff; present_in = present_ff;
      best_in = best_ff; rsp_in = 1'b0; last_rd_in = last_rd_ff;
      mod_start = 1'b0; we = 1'b0; wdata = sat_sum;
      addr = ADDR_W'({sw_ff, row_ff, idx_ff[row_ff]});
      unique case (state_ff)
         cms_pkg::ST_CLEAR: begin
            we = 1'b1; wdata = '0; addr = clr_ff[ADDR_W-1:0];
            clr_in = clr_ff + 1'b1;
         end
         cms_pkg::ST_IDLE: begin
            row_in = '0; mod_busy_in = 1'b0;
         end
         cms_pkg::ST_HASH: begin
            row_in = '0; mod_busy_in = 1'b0;
         end
         cms_pkg::ST_MOD: begin
            if (!mod_busy_ff) begin
               mod_start = 1'b1; mod_busy_in = 1'b1;
            end else if (mod_done) begin
               mod_busy_in = 1'b0;
               if (row_ff == ROW_W'(ROWS - 1)) begin
                  row_in = '0; phase_in = 1'b0; last_rd_in = 1'b0;
                  best_in = cms_pkg::SENTINEL;
                  sw_in = (req_ff.kind == cms_pkg::KIND_ADD) ? SW_W'(req_ff.switch_id) : '0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         cms_pkg::ST_ACCESS: begin
            if (req_ff.kind == cms_pkg::KIND_ADD) begin
               // read, then write back the saturated sum
               we = phase_ff;
               phase_in = !phase_ff;
               if (phase_ff) begin
                  present_in[sw_ff] = 1'b1;
                  row_in = row_ff + 1'b1;
               end
            end else begin
               // fold in the previous read, then issue the next one
               if (rvld_ff && rdata_ff < best_ff) best_in = rdata_ff;
               if (!last_rd_ff) begin
                  rvld_in = present_ff[sw_ff];
                  if (row_ff == ROW_W'(ROWS - 1)) begin
                     row_in = '0;
                     if (sw_ff == SW_W'(NUM_SWITCHES - 1)) last_rd_in = 1'b1;
                     else sw_in = sw_ff + 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else if (!rvld_ff) begin
                  rvld_in = 1'b1;   // drain slot so the exit condition fires
                  addr = '0;
               end
            end
         end
         cms_pkg::ST_DONE: rsp_in = 1'b1;
         default: ;
      endcase
   end

   // query drain: keep the read data of the drain slot out of the minimum
   logic rd_real_ff, rd_real_in;
   logic rvld_q;
   assign rd_real_in = !last_rd_ff && present_ff[sw_ff];
   assign rvld_q = rvld_ff && !(last_rd_ff && state_ff == cms_pkg::ST_ACCESS
                   && req_ff.kind == cms_pkg::KIND_QUERY && !rd_real_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cms_pkg::ST_CLEAR;
         clr_ff     <= '0;
         present_ff <= '0;
         rsp_ff     <= 1'b0;
         rvld_ff    <= 1'b0;
         mod_busy_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         present_ff <= present_in;
         rsp_ff     <= rsp_in;
         rvld_ff    <= rvld_in;
         mod_busy_ff <= mod_busy_in;
      end
      sw_ff <= sw_in; row_ff <= row_in; phase_ff <= phase_in;
      last_rd_ff <= last_rd_in; rd_real_ff <= rd_real_in;
      // drop drain-slot data from the minimum
      best_ff <= (rvld_ff && !rvld_q) ? best_ff : best_in;
   end

   assign busy                = (state_ff != cms_pkg::ST_IDLE);
   assign rsp_valid           = rsp_ff;
   assign rsp_data.estimate   = best_ff;
   assign rsp_data.any_switch = |present_ff;
endmodule
`default_nettype wire
